>>> rtl/pvp_pkg.sv
// ----------------------------------------------------------------------------
// pvp_pkg
// Shared widths, constants and the pipeline item type for the vertex projector.
// ----------------------------------------------------------------------------
`default_nettype none

package pvp_pkg;

    localparam int COORD_W  = 32;
    localparam int SCALE_W  = 24;
    localparam int CENTER_W = 12;
    localparam int SCREEN_W = 16;
    localparam int PROD_W   = SCALE_W + COORD_W + 1;   // signed product
    localparam int MAG_W    = PROD_W - 1;              // magnitude of product
    localparam int QUOT_W   = 25;                      // quotient bits kept
    localparam int ADDR_W   = 4;

    localparam logic [SCALE_W-1:0]  SCALE_RESET    = 24'd6400;
    localparam logic [CENTER_W-1:0] CENTER_X_RESET = 12'd160;
    localparam logic [CENTER_W-1:0] CENTER_Y_RESET = 12'd120;

    localparam logic signed [SCREEN_W-1:0] BEHIND_MARK = -16'sd10000;

    // register indexes
    typedef enum logic [1:0] {
        REG_SCALE    = 2'd0,
        REG_CENTER_X = 2'd1,
        REG_CENTER_Y = 2'd2
    } reg_idx_t;

    // one pipeline slot; later stages fill the later fields
    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  z;
        logic        [COORD_W-1:0]  d;
        logic                       last;
        logic                       behind;
        logic signed [PROD_W-1:0]   px;
        logic signed [PROD_W-1:0]   pz;
        logic        [MAG_W-1:0]    rx;
        logic        [MAG_W-1:0]    rz;
        logic                       negx;
        logic                       negz;
        logic                       ovfx;
        logic                       ovfz;
        logic        [QUOT_W-1:0]   qx;
        logic        [QUOT_W-1:0]   qz;
        logic signed [SCREEN_W-1:0] sx;
        logic signed [SCREEN_W-1:0] sy;
    } item_t;

endpackage

`default_nettype wire

>>> rtl/perspective_vertex_project.sv
// ----------------------------------------------------------------------------
// perspective_vertex_project
// Pinhole projection of camera-space vertices to saturated screen pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one vertex per item: s_tdata = {vert_z, vert_depth, vert_x}
//   (vert_x lowest), s_tlast = last_vertex. m_* returns one result per item:
//   m_tdata = {screen_y, screen_x}, m_tuser = behind_viewer,
//   m_tlast = end_of_list. Registers sit on the APB port: scale at 0x0,
//   centre x at 0x4, centre y at 0x8; write only while the stream is idle.
//   An item passes from acceptance to m_tvalid through 29 register
//   stages: input register, a 24x32 multiply, sign/overflow stage,
//   25 restoring-division steps (one quotient bit per stage, both axes side
//   by side) and the output stage.
//   Throughput is one item per cycle. Each stage holds its item while the
//   next one is full and stalled, so a stall on m_tready fills the bubbles
//   first and back-pressures s_tready only when every stage is occupied.
//   Reset clears all stage valids and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module perspective_vertex_project (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // vert_x, vert_depth, vert_z
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // screen_x, screen_y
    output logic             m_tuser,   // behind_viewer
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [pvp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pvp_pkg::*;

    localparam int DIV_FIRST = 3;
    localparam int NST       = DIV_FIRST + QUOT_W + 1;
    localparam int OUT_ST    = NST - 1;

    logic [SCALE_W-1:0]  scale_reg;
    logic [CENTER_W-1:0] cx_reg;
    logic [CENTER_W-1:0] cy_reg;
    logic                wr_en;
    reg_idx_t            widx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            cx_reg    <= CENTER_X_RESET;
            cy_reg    <= CENTER_Y_RESET;
        end
        else if (wr_en)
        begin
            case (widx)
                REG_SCALE:    scale_reg <= pwdata[SCALE_W-1:0];
                REG_CENTER_X: cx_reg    <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y: cy_reg    <= pwdata[CENTER_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_SCALE:    prdata = {8'h00, scale_reg};
            REG_CENTER_X: prdata = {20'h0, cx_reg};
            REG_CENTER_Y: prdata = {20'h0, cy_reg};
            default:      prdata = 32'h0;
        endcase
    end

    // pipeline
    item_t           st_reg [NST];
    item_t           st_next[NST];
    logic [NST-1:0]  v_reg;
    logic [NST:0]    rdy;
    logic [NST-1:0]  v_in;

    assign rdy[NST] = m_tready;
    assign v_in[0]  = s_tvalid;
    assign s_tready = rdy[0];

    logic signed [SCREEN_W-1:0] fin_x;
    logic signed [SCREEN_W-1:0] fin_y;

    pvp_finish u_fin_x (
        .quot   (st_reg[OUT_ST-1].qx),
        .neg    (st_reg[OUT_ST-1].negx),
        .ovf    (st_reg[OUT_ST-1].ovfx),
        .center (cx_reg),
        .coord  (fin_x)
    );

    pvp_finish u_fin_y (
        .quot   (st_reg[OUT_ST-1].qz),
        .neg    (st_reg[OUT_ST-1].negz),
        .ovf    (st_reg[OUT_ST-1].ovfz),
        .center (cy_reg),
        .coord  (fin_y)
    );

    genvar k;
    generate
        for (k = 0; k < NST; k++)
        begin : g_st
            assign rdy[k] = !v_reg[k] || rdy[k+1];
            if (k > 0)
            begin : g_vin
                assign v_in[k] = v_reg[k-1];
            end

            if (k == 0)
            begin : g_in
                always_comb
                begin
                    st_next[k]      = '0;
                    st_next[k].x    = $signed(s_tdata[31:0]);
                    st_next[k].d    = s_tdata[63:32];
                    st_next[k].z    = $signed(s_tdata[95:64]);
                    st_next[k].last = s_tlast;
                end
            end
            else if (k == 1)
            begin : g_mul
                always_comb
                begin
                    st_next[k]        = st_reg[k-1];
                    st_next[k].behind = ($signed(st_reg[k-1].d) <= 0);
                    st_next[k].px     = $signed({1'b0, scale_reg}) * st_reg[k-1].x;
                    st_next[k].pz     = $signed({1'b0, scale_reg}) * st_reg[k-1].z;
                end
            end
            else if (k == 2)
            begin : g_abs
                logic signed [PROD_W-1:0] ax;
                logic signed [PROD_W-1:0] az;
                logic        [MAG_W-1:0]  dlim;
                always_comb
                begin
                    ax   = st_reg[k-1].px[PROD_W-1] ? -st_reg[k-1].px : st_reg[k-1].px;
                    az   = st_reg[k-1].pz[PROD_W-1] ? -st_reg[k-1].pz : st_reg[k-1].pz;
                    dlim = {st_reg[k-1].d[COORD_W-2:0], {QUOT_W{1'b0}}};
                    st_next[k]      = st_reg[k-1];
                    st_next[k].rx   = ax[MAG_W-1:0];
                    st_next[k].rz   = az[MAG_W-1:0];
                    // y axis uses the negated product
                    st_next[k].negx = st_reg[k-1].px[PROD_W-1];
                    st_next[k].negz = !st_reg[k-1].pz[PROD_W-1];
                    st_next[k].ovfx = (ax[MAG_W-1:0] >= dlim);
                    st_next[k].ovfz = (az[MAG_W-1:0] >= dlim);
                    st_next[k].qx   = '0;
                    st_next[k].qz   = '0;
                end
            end
            else if (k < OUT_ST)
            begin : g_div
                localparam int BIT = QUOT_W - 1 - (k - DIV_FIRST);
                logic [MAG_W-1:0] dsh;
                always_comb
                begin
                    dsh = {{(MAG_W-COORD_W+1){1'b0}}, st_reg[k-1].d[COORD_W-2:0]} << BIT;
                    st_next[k] = st_reg[k-1];
                    if (st_reg[k-1].rx >= dsh)
                    begin
                        st_next[k].rx      = st_reg[k-1].rx - dsh;
                        st_next[k].qx[BIT] = 1'b1;
                    end
                    if (st_reg[k-1].rz >= dsh)
                    begin
                        st_next[k].rz      = st_reg[k-1].rz - dsh;
                        st_next[k].qz[BIT] = 1'b1;
                    end
                end
            end
            else
            begin : g_out
                always_comb
                begin
                    st_next[k]    = st_reg[k-1];
                    st_next[k].sx = st_reg[k-1].behind ? BEHIND_MARK : fin_x;
                    st_next[k].sy = st_reg[k-1].behind ? BEHIND_MARK : fin_y;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (rdy[k])
                    v_reg[k] <= v_in[k];
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k] && v_in[k])
                    st_reg[k] <= st_next[k];
            end
        end
    endgenerate

    assign m_tvalid = v_reg[OUT_ST];
    assign m_tdata  = {st_reg[OUT_ST].sy, st_reg[OUT_ST].sx};
    assign m_tuser  = st_reg[OUT_ST].behind;
    assign m_tlast  = st_reg[OUT_ST].last;

    a_behind_mark: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[15:0] == BEHIND_MARK
                             && m_tdata[31:16] == BEHIND_MARK)
        else $error("behind item without marker coordinates");

    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted item missing from first stage");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[OUT_ST-1] && !rdy[OUT_ST-1] |=> v_reg[OUT_ST-1] && v_reg[OUT_ST])
        else $error("stalled stage lost its item");

endmodule

`default_nettype wire

>>> rtl/pvp_finish.sv
// ----------------------------------------------------------------------------
// pvp_finish
// Applies sign, adds the centre, truncates toward zero and saturates one axis.
// ----------------------------------------------------------------------------
`default_nettype none

module pvp_finish (
    input  wire logic [pvp_pkg::QUOT_W-1:0]          quot,
    input  wire logic                                neg,
    input  wire logic                                ovf,
    input  wire logic [pvp_pkg::CENTER_W-1:0]        center,
    output logic signed [pvp_pkg::SCREEN_W-1:0]      coord
);
    import pvp_pkg::*;

    localparam int SUM_W = QUOT_W + 3;

    logic signed [SUM_W-1:0] qs;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] rnd;

    always_comb
    begin
        qs  = neg ? -$signed({3'b000, quot}) : $signed({3'b000, quot});
        sum = qs + $signed({{(SUM_W-CENTER_W-8){1'b0}}, center, 8'h00});
        // Q.8 to integer, toward zero
        rnd = sum[SUM_W-1] ? ((sum + SUM_W'(255)) >>> 8) : (sum >>> 8);
        if (ovf)
            coord = neg ? -16'sd32768 : 16'sd32767;
        else if (rnd > SUM_W'(32767))
            coord = 16'sd32767;
        else if (rnd < -$signed(SUM_W'(32768)))
            coord = -16'sd32768;
        else
            coord = rnd[SCREEN_W-1:0];
    end

endmodule

`default_nettype wire
